// ===== rtl/core/svbe_pkg.sv =====
// svbe_pkg: item types and constants for the signed varint byte encoder
// no dependencies; used by signed_varint_byte_encoder_core and the bench
package svbe_pkg;

  // bits carried by one output byte
  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned VALUE_BITS = 64;

  // what the item asks for
  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_RAW    = 1'b1
  } action_t;

  typedef struct packed {
    action_t                       action;
    logic signed [VALUE_BITS-1:0]  value;
    logic        [BYTE_BITS-1:0]   raw_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last;
  } result_t;

endpackage

// ===== rtl/core/signed_varint_byte_encoder_core.sv =====
// signed_varint_byte_encoder_core: top level of the signed varint encoder
// depends on svbe_pkg and svbe_code_map
//
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+------------------------------
//  item     | item_valid    | item_stall    | item   (action, value, raw_byte)
//  result   | result_valid  | result_stall  | result (out_byte, last)
//
// one output byte per cycle while result_stall is low, shifting 7 bits per byte;
// an item gives ceil(code bits / 7) bytes, 1 to 10 at VALUE_WIDTH 64; raw gives one
// a new item is taken in the same cycle the last byte of the previous one leaves
// rst is synchronous and active high; it only empties the output register
// a stalled result holds its byte; items wait while a run is in progress
module signed_varint_byte_encoder_core #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  svbe_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output svbe_pkg::result_t result
);

  localparam int unsigned CODE_WIDTH = VALUE_WIDTH + 1;

  logic                  busy;
  logic                  busy_next;
  logic                  raw;
  logic                  raw_next;
  logic [CODE_WIDTH-1:0] sr;
  logic [CODE_WIDTH-1:0] sr_next;
  logic [CODE_WIDTH-1:0] code;
  logic                  item_fire;
  logic                  result_fire;
  logic                  at_last;

  // sign-magnitude code of the incoming value
  svbe_code_map #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_code_map (
    .value(item.value[VALUE_WIDTH-1:0]),
    .code (code)
  );

  // last byte of a run: raw item, or nothing left above the low group
  assign at_last = raw || (sr[CODE_WIDTH-1:svbe_pkg::GROUP_BITS] == '0);

  // result payload straight from the shift register
  always_comb begin
    result_valid    = busy;
    result.last     = at_last;
    if (raw) begin
      result.out_byte = sr[svbe_pkg::BYTE_BITS-1:0];
    end else begin
      result.out_byte = {~at_last, sr[svbe_pkg::GROUP_BITS-1:0]};
    end
  end

  // handshakes
  assign result_fire = result_valid && !result_stall;
  assign item_stall  = busy && !(result_fire && at_last);
  assign item_fire   = item_valid && !item_stall;

  // load on a new item, shift one group per delivered byte
  always_comb begin
    busy_next = busy;
    raw_next  = raw;
    sr_next   = sr;
    if (result_fire) begin
      if (at_last) begin
        busy_next = 1'b0;
      end else begin
        sr_next = sr >> svbe_pkg::GROUP_BITS;
      end
    end
    if (item_fire) begin
      busy_next = 1'b1;
      raw_next  = (item.action == svbe_pkg::ACT_RAW);
      if (item.action == svbe_pkg::ACT_RAW) begin
        sr_next = CODE_WIDTH'(item.raw_byte);
      end else begin
        sr_next = code;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    raw <= raw_next;
    sr  <= sr_next;
  end

`ifndef NO_ASSERTIONS
  // an accepted item always shows a result next cycle
  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_fire |=> result_valid)
    else $error("accepted item produced no result");

  // a run keeps going until its last byte is taken
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (result_fire && !result.last) |=> result_valid)
    else $error("run ended before its last byte");

  // a raw item is a single byte
  a_raw_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && raw) |-> result.last)
    else $error("raw item not marked last");

  // idle encoder takes items
  a_idle_accepts: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("idle encoder stalled items");
`endif

endmodule

// ===== rtl/core/svbe_code_map.sv =====
// svbe_code_map: maps a two's complement value to 2*|v| + sign
// depends on nothing but its parameter; instantiated by the encoder core
module svbe_code_map #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic [VALUE_WIDTH-1:0] value,
  output logic [VALUE_WIDTH:0]   code
);

  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;

  // magnitude; the most negative value comes out as 2^(w-1) unsigned
  always_comb begin
    neg = value[VALUE_WIDTH-1];
    mag = neg ? (~value + VALUE_WIDTH'(1)) : value;
  end

  // sign goes into the low bit of the code
  assign code = {mag, neg};

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for signed_varint_byte_encoder_core
// predicts the sign-magnitude varint bytes of each item and checks them in order
// depends on svbe_pkg and the rtl/core sources
`timescale 1ns / 100ps

module tb;

  // expected output bytes per item, checked in arrival order
  class varint_byte_scoreboard;
    svbe_pkg::result_t expected_bytes[$];
    int                mismatches;

    function new();
      mismatches = 0;
    endfunction

    // work out the bytes an accepted item must produce
    function void predict_item(svbe_pkg::item_t it);
      logic [svbe_pkg::VALUE_BITS:0]   code;
      logic [svbe_pkg::VALUE_BITS-1:0] mag;
      logic                            neg;
      svbe_pkg::result_t               r;
      if (it.action == svbe_pkg::ACT_RAW) begin
        r.out_byte = it.raw_byte;
        r.last     = 1'b1;
        expected_bytes.push_back(r);
        return;
      end
      neg = it.value[svbe_pkg::VALUE_BITS-1];
      // most negative value wraps back to 2^63 here, which is the exact magnitude
      mag = neg ? (~it.value + 1'b1) : it.value;
      code = {mag, neg};
      while (code > 127) begin
        r.out_byte = {1'b1, code[6:0]};
        r.last     = 1'b0;
        expected_bytes.push_back(r);
        code = code >> svbe_pkg::GROUP_BITS;
      end
      r.out_byte = {1'b0, code[6:0]};
      r.last     = 1'b1;
      expected_bytes.push_back(r);
    endfunction

    // compare one accepted output byte with the oldest expectation
    function void check_byte(svbe_pkg::result_t got);
      svbe_pkg::result_t exp;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected byte %02h last %0b with nothing pending",
                   $realtime, got.out_byte, got.last);
        return;
      end
      exp = expected_bytes.pop_front();
      if (got.out_byte !== exp.out_byte || got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                   $realtime, exp.out_byte, exp.last, got.out_byte, got.last);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  svbe_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  svbe_pkg::result_t result;

  varint_byte_scoreboard sb;
  bit                calm;
  int                stall_left = 0;
  logic              byte_taken;
  svbe_pkg::result_t byte_seen;

  signed_varint_byte_encoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // encode item; raw_byte is don't-care but still random
  function automatic svbe_pkg::item_t encode_item(
    logic signed [svbe_pkg::VALUE_BITS-1:0] v);
    svbe_pkg::item_t it;
    it.action   = svbe_pkg::ACT_ENCODE;
    it.value    = v;
    it.raw_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // raw byte item; value is don't-care but still random
  function automatic svbe_pkg::item_t raw_item(logic [svbe_pkg::BYTE_BITS-1:0] b);
    svbe_pkg::item_t it;
    it.action   = svbe_pkg::ACT_RAW;
    it.value    = {$urandom, $urandom};
    it.raw_byte = b;
    return it;
  endfunction

  // random value spread over all byte counts, with extra weight near group edges
  function automatic logic signed [svbe_pkg::VALUE_BITS-1:0] random_value();
    logic [svbe_pkg::VALUE_BITS-1:0] mag;
    int                              nbits;
    if ($urandom_range(0, 3) == 0) begin
      nbits = $urandom_range(0, 63);
      mag = (64'd1 << nbits) - 64'($urandom_range(0, 1));
    end else begin
      nbits = $urandom_range(0, 64);
      mag = {$urandom, $urandom};
      if (nbits < 64)
        mag = mag & ((64'd1 << nbits) - 64'd1);
    end
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // present one item, with an optional idle burst first, and hold it until taken
  task automatic send_item(input svbe_pkg::item_t it);
    logic taken;
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (!item_stall) begin
        taken = 1'b1;
        sb.predict_item(it);
      end
      @(posedge clk);
    end
  endtask

  // receiver stalls in random bursts
  always begin
    @(posedge clk);
    if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 12);
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // sample output mid-cycle, check it at the edge that accepts it
  always begin
    @(negedge clk);
    byte_taken = result_valid && !result_stall;
    byte_seen  = result;
    @(posedge clk);
    if (byte_taken === 1'b1)
      sb.check_byte(byte_seen);
  end

  // stimulus and end of run
  initial begin
    sb = new();
    calm = 1'b0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: zero, group edges, extremes, most negative, raw bytes
    send_item(encode_item(64'sd0));
    send_item(encode_item(64'sd1));
    send_item(encode_item(-64'sd1));
    send_item(encode_item(64'sd63));
    send_item(encode_item(64'sd64));
    send_item(encode_item(-64'sd64));
    send_item(encode_item(-64'sd65));
    send_item(encode_item(64'sd8191));
    send_item(encode_item(64'sd8192));
    send_item(encode_item(-64'sd8192));
    send_item(encode_item(64'sh7FFF_FFFF_FFFF_FFFF));
    send_item(encode_item(64'sh8000_0000_0000_0001));
    send_item(encode_item(64'sh8000_0000_0000_0000));
    send_item(encode_item(64'sh4000_0000_0000_0000));
    send_item(encode_item(64'sh3FFF_FFFF_FFFF_FFFF));
    send_item(encode_item(-64'sh4000_0000_0000_0000));
    send_item(raw_item(8'h00));
    send_item(raw_item(8'hFF));
    send_item(raw_item(8'h80));
    send_item(raw_item(8'h7F));
    send_item(encode_item(64'sh5555_5555_5555_5555));
    send_item(encode_item(64'shAAAA_AAAA_AAAA_AAAA));

    // random part; the last stretch runs without idling on either side
    for (int i = 0; i < 270; i++) begin
      if (i == 230)
        calm = 1'b1;
      if ($urandom_range(0, 3) == 0)
        send_item(raw_item(8'($urandom_range(0, 255))));
      else
        send_item(encode_item(random_value()));
    end
    item_valid <= 1'b0;

    while (sb.expected_bytes.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
      $display("signed_varint_byte_encoder_core regression: pass");
    else
      $display("signed_varint_byte_encoder_core regression: fail");
    $finish;
  end

  // hard limit on run time
  initial begin
    #4_000_000;
    $display("signed_varint_byte_encoder_core regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/svbe_pkg.sv
rtl/core/svbe_code_map.sv
rtl/core/signed_varint_byte_encoder_core.sv
bench/tb.sv
